>>> design/assert_macros.svh
// Assertion macros shared by the sort key encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, suspended while rst_n is low.
`define U8SK_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define U8SK_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/u8sk_pkg.sv
// Shared types, constants and fold tables for the UTF-8 sort key encoder.
package u8sk_pkg;

  localparam int BYTE_W      = 8;
  localparam int CODE_W      = 21;
  localparam int WORD_W      = 15;
  localparam int TDATA_OUT_W = 16;
  localparam int QUEUE_DEPTH = 4;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [1:0]        rem_t;

  typedef struct packed {
    logic  valid;
    code_t code;
  } u8sk_push_t;

  localparam logic [7:0] LATIN1_ROM [32] = '{
    "a", "a", "a", "a", "a", "a", "a", "c",
    "e", "e", "e", "e", "i", "i", "i", "i",
    "d", "n", "o", "o", "o", "o", "o", "o",
    "o", "u", "u", "u", "u", "y", "t", "s"
  };

  localparam logic [7:0] LATIN_EXT_A_ROM [64] = '{
    "a", "a", "a", "c", "c", "c", "c", "d",
    "d", "e", "e", "e", "e", "e", "g", "g",
    "g", "g", "h", "h", "i", "i", "i", "i",
    "i", "i", "j", "k", "k", "l", "l", "l",
    "l", "l", "n", "n", "n", "n", "o", "o",
    "o", "o", "r", "r", "r", "s", "s", "s",
    "s", "t", "t", "t", "u", "u", "u", "u",
    "u", "u", "w", "y", "z", "z", "z", "z"
  };

  // Case fold and Latin-1 / Latin Extended-A transliteration.
  function automatic code_t fold_code(input code_t cp);
    code_t r;
    r = cp;
    if (cp[CODE_W-1:8] == '0) begin
      if (cp[7:0] >= 8'h41 && cp[7:0] <= 8'h5A) begin
        r = cp + code_t'(8'h20);
      end else if (cp[7:0] >= 8'hC0) begin
        r = code_t'(LATIN1_ROM[cp[4:0]]);
      end
    end else if (cp[CODE_W-1:8] == (CODE_W-8)'(1) && !cp[7]) begin
      r = code_t'(LATIN_EXT_A_ROM[cp[6:1]]);
    end
    return r;
  endfunction

endpackage

>>> design/u8sk_front.sv
// Front end: UTF-8 byte decoder and codepoint fold, pushes finished codes.
`include "assert_macros.svh"

module u8sk_front
  import u8sk_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,   // [7:0] byte_in
  input  logic              q_full,
  output u8sk_push_t        push
);

  code_t partial_r, partial_nxt;
  rem_t  rem_r, rem_nxt;
  code_t shifted;
  logic  accept;
  logic [BYTE_W-1:0] b;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign shifted   = {partial_r[CODE_W-7:0], b[5:0]};

  always_comb begin
    partial_nxt = partial_r;
    rem_nxt     = rem_r;
    push.valid  = 1'b0;
    push.code   = fold_code(shifted);
    if (accept) begin
      priority if (b == '0) begin
        partial_nxt = '0;
        rem_nxt     = '0;
      end else if (rem_r == '0) begin
        priority if (!b[7]) begin
          push.valid = 1'b1;
          push.code  = fold_code(code_t'(b));
        end else if (b[7:5] == 3'b110) begin
          partial_nxt = code_t'(b[4:0]);
          rem_nxt     = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          partial_nxt = code_t'(b[3:0]);
          rem_nxt     = 2'd2;
        end else begin
          partial_nxt = code_t'(b[2:0]);
          rem_nxt     = 2'd3;
        end
      end else begin
        rem_nxt = rem_r - 2'd1;
        if (rem_r == 2'd1) begin
          push.valid  = 1'b1;
          partial_nxt = '0;
        end else begin
          partial_nxt = shifted;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      rem_r     <= '0;
    end else begin
      partial_r <= partial_nxt;
      rem_r     <= rem_nxt;
    end
  end

  `U8SK_ASSERT(a_idle_partial_clear, (rem_r == '0) |-> (partial_r == '0), "partial left set")
  `U8SK_ASSERT(a_push_on_accept, push.valid |-> (in_tvalid && in_tready), "push without request")

endmodule

>>> design/u8sk_queue.sv
// Small code queue between the decoder and the word serializer.
`include "assert_macros.svh"

module u8sk_queue
  import u8sk_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
)(
  input  logic       clk,
  input  logic       rst_n,
  input  u8sk_push_t push,
  output logic       full,
  input  logic       pop,
  output code_t      head_code,
  output logic       empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  code_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign head_code = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + CW'(push.valid) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.code;
    end
  end

  `U8SK_ASSERT(a_count_bound, count_r <= CW'(DEPTH), "queue overfilled")
  `U8SK_ASSERT(a_no_push_full, push.valid |-> !full, "push into full queue")
  `U8SK_ASSERT(a_no_pop_empty, pop |-> !empty, "pop from empty queue")

endmodule

>>> design/u8sk_back.sv
// Back end: splits each code into one or two 15-bit words, registered output.
`include "assert_macros.svh"

module u8sk_back
  import u8sk_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  code_t                  head_code,
  input  logic                   empty,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [TDATA_OUT_W-1:0] out_tdata,  // [14:0] sort_word, [15] zero
  output logic                   out_tlast   // last_word
);

  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic              last_r, last_nxt;
  logic              hi_done_r, hi_done_nxt;
  logic              load;
  logic              two_words;

  assign load      = !empty && (!out_valid_r || out_tready);
  assign two_words = (head_code[CODE_W-1:WORD_W] != '0);

  always_comb begin
    word_nxt      = word_r;
    last_nxt      = last_r;
    hi_done_nxt   = hi_done_r;
    pop           = 1'b0;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (two_words && !hi_done_r) begin
        word_nxt    = WORD_W'(head_code[CODE_W-1:WORD_W]);
        last_nxt    = 1'b0;
        hi_done_nxt = 1'b1;
      end else begin
        word_nxt    = head_code[WORD_W-1:0];
        last_nxt    = 1'b1;
        hi_done_nxt = 1'b0;
        pop         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hi_done_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      hi_done_r   <= hi_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_OUT_W'(word_r);
  assign out_tlast  = last_r;

  `U8SK_ASSERT(a_hi_keeps_head, hi_done_r |-> !empty, "head lost before low word")
  `U8SK_ASSERT(a_hi_word_phase, (out_valid_r && !last_r) |-> hi_done_r, "high word out of phase")

endmodule

>>> design/utf8_sort_key_encoder.sv
// UTF-8 sort key encoder top level: decoder, code queue and word serializer.
//
// Takes one UTF-8 byte per request on the in_ channel and, for each completed
// character, gives the case-folded / transliterated codepoint on the out_
// channel: one 15-bit word with tlast set when the code is below 0x8000,
// otherwise the high bits first (tlast low) and then the low 15 bits. A zero
// byte drops any partial sequence and gives nothing. The decoder takes a byte
// every cycle while the code queue has room; the serializer gives one word per
// cycle while the code queue holds a code and the out_ receiver is ready. The
// finished code of a character passes through the code queue and then the
// registered output word on its way to the out_ channel.
module utf8_sort_key_encoder
  import u8sk_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // [7:0] byte_in
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [TDATA_OUT_W-1:0] out_tdata,  // [14:0] sort_word, [15] zero
  output logic                   out_tlast   // last_word
);

  u8sk_push_t push;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  code_t      head_code;

  u8sk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push)
  );

  u8sk_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (q_full),
    .pop       (q_pop),
    .head_code (head_code),
    .empty     (q_empty)
  );

  u8sk_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_code  (head_code),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> verif/utf8_sort_key_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the UTF-8 sort key encoder: predicts sort key words and checks the out_ stream.
module utf8_sort_key_checker
  import u8sk_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [TDATA_OUT_W-1:0] out_tdata,
  input  logic                   out_tlast,
  output int                     mismatch_count,
  output int                     words_pending
);

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } key_word_t;

  // first letter sits in the top byte
  localparam logic [8*32-1:0] LATIN1_LETTERS = "aaaaaaaceeeeiiiidnooooooouuuuyts";
  localparam logic [8*64-1:0] EXT_A_LETTERS =
    "aaaccccddeeeeegggghhiiiiiijkklllllnnnnoooorrrsssstttuuuuuuwyzzzz";

  key_word_t pending_keys[$];
  code_t     partial_cp;
  rem_t      cont_left;
  int        errors;

  initial errors = 0;

  function automatic code_t fold_codepoint(input code_t cp);
    int idx;
    if (cp[CODE_W-1:8] == '0) begin
      if (cp >= code_t'(8'h41) && cp <= code_t'(8'h5A)) return cp + code_t'(8'h20);
      if (cp >= code_t'(8'hC0)) begin
        idx = 31 - int'(cp[4:0]);
        return code_t'(LATIN1_LETTERS[8*idx +: 8]);
      end
      return cp;
    end
    if (cp[CODE_W-1:8] == (CODE_W-8)'(1) && cp < code_t'(12'h180)) begin
      idx = 63 - int'(cp[6:1]);
      return code_t'(EXT_A_LETTERS[8*idx +: 8]);
    end
    return cp;
  endfunction

  task automatic queue_key(input code_t cp);
    code_t folded;
    folded = fold_codepoint(cp);
    if (folded < code_t'(16'h8000)) begin
      pending_keys.push_back('{word: folded[WORD_W-1:0], last: 1'b1});
    end else begin
      pending_keys.push_back('{word: WORD_W'(folded >> WORD_W), last: 1'b0});
      pending_keys.push_back('{word: folded[WORD_W-1:0], last: 1'b1});
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    if (b == 8'h00) begin
      partial_cp = '0;
      cont_left  = '0;
    end else if (cont_left == 2'd0) begin
      if (!b[7]) begin
        queue_key(code_t'(b));
      end else if (b[7:5] == 3'b110) begin
        partial_cp = code_t'(b[4:0]);
        cont_left  = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        partial_cp = code_t'(b[3:0]);
        cont_left  = 2'd2;
      end else begin
        // stray continuation and 0xF8.. leads open a 4-byte sequence
        partial_cp = code_t'(b[2:0]);
        cont_left  = 2'd3;
      end
    end else begin
      partial_cp = {partial_cp[CODE_W-7:0], b[5:0]};
      cont_left  = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        queue_key(partial_cp);
        partial_cp = '0;
      end
    end
  endtask

  always @(posedge clk) begin
    key_word_t exp_word;
    if (!rst_n) begin
      partial_cp = '0;
      cont_left  = '0;
      pending_keys.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_keys.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected word %h last %b", $realtime, out_tdata, out_tlast);
          errors++;
        end else begin
          exp_word = pending_keys.pop_front();
          if (out_tdata[WORD_W-1:0] !== exp_word.word || out_tlast !== exp_word.last) begin
            if (errors < 10)
              $display("%0t: word mismatch: expected %h last %b, got %h last %b",
                       $realtime, exp_word.word, exp_word.last,
                       out_tdata[WORD_W-1:0], out_tlast);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) decode_byte(in_tdata);
    end
    mismatch_count <= errors;
    words_pending  <= pending_keys.size();
  end

endmodule

>>> verif/utf8_sort_key_encoder_test.sv
`timescale 1ns / 100ps
// Testbench top for the UTF-8 sort key encoder: clock, reset, byte stimulus and verdict.
module utf8_sort_key_encoder_test;
  import u8sk_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] out_tdata;
  logic                   out_tlast;

  int mismatch_count;
  int words_pending;
  int tx_idle_pct = 31;
  int rx_idle_pct = 58;
  int stall_requests = 0;
  int stalls_done = 0;
  int bytes_sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  utf8_sort_key_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  utf8_sort_key_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending)
  );

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  task automatic send_char();
    int kind;
    int n;
    logic [7:0] lead;
    kind = $urandom_range(99);
    if (kind < 30) begin
      send_byte(8'($urandom_range(1, 127)));
    end else if (kind < 45) begin
      if ($urandom_range(1)) lead = 8'($urandom_range(8'hC3, 8'hC6));
      else lead = 8'($urandom_range(8'hC0, 8'hDF));
      send_byte(lead);
      send_byte(8'($urandom_range(8'h80, 8'hBF)));
    end else if (kind < 57) begin
      send_byte(8'($urandom_range(8'hE0, 8'hEF)));
      repeat (2) send_byte(8'($urandom_range(8'h80, 8'hBF)));
    end else if (kind < 67) begin
      send_byte(8'($urandom_range(8'hF0, 8'hF7)));
      repeat (3) send_byte(8'($urandom_range(8'h80, 8'hBF)));
    end else if (kind < 75) begin
      // stray continuation or 0xF8.. lead, then random nonzero bytes
      if ($urandom_range(1)) send_byte(8'($urandom_range(8'h80, 8'hBF)));
      else send_byte(8'($urandom_range(8'hF8, 8'hFF)));
      repeat (3) send_byte(8'($urandom_range(1, 255)));
    end else if (kind < 83) begin
      n = $urandom_range(1, 3);
      case (n)
        1: send_byte(8'($urandom_range(8'hC0, 8'hDF)));
        2: send_byte(8'($urandom_range(8'hE0, 8'hEF)));
        default: send_byte(8'($urandom_range(8'hF0, 8'hF7)));
      endcase
      repeat (n) send_byte(8'($urandom_range(1, 255)));
    end else if (kind < 90) begin
      // lead byte, up to two continuation bytes, then an end-of-string zero byte
      n = $urandom_range(0, 2);
      send_byte(8'($urandom_range(8'hC0, 8'hFF)));
      repeat (n) send_byte(8'($urandom_range(8'h80, 8'hBF)));
      send_byte(8'h00);
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_random(input int count);
    int target;
    target = bytes_sent + count;
    while (bytes_sent < target) send_char();
  endtask

  initial begin
    logic [7:0] directed_bytes[$];
    directed_bytes = '{
      8'h41, 8'h5A, 8'h7F,
      8'hC3, 8'h80,
      8'hC5, 8'hBF,
      8'hC6, 8'h80,
      8'hEF, 8'hBF, 8'hBF,
      8'hF7, 8'hBF, 8'hBF, 8'hBF,
      8'h80, 8'h41, 8'h42, 8'h43,
      8'hE2, 8'h82, 8'h00,
      8'h41
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    send_random(400);
    wait_drained();

    tx_idle_pct = 58;
    rx_idle_pct = 31;
    send_random(400);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    stall_requests++;
    repeat (40) send_byte(8'($urandom_range(8'h41, 8'h7A)));
    send_random(360);
    wait_drained();
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (stall_requests != stalls_done) begin
        stalls_done++;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    #3600000;
    $display("FAILURE");
    $finish;
  end

endmodule
